/* hw/rtl/frlm_pkg.sv */
// shared types and codes for the fifo resource lock manager
package frlm_pkg;

  localparam int unsigned KindW   = 1;
  localparam int unsigned ClientW = 3;
  localparam int unsigned ResW    = 2;
  localparam int unsigned ErrW    = 2;

  localparam logic [KindW-1:0] KIND_REQUEST = 1'b0;
  localparam logic [KindW-1:0] KIND_RELEASE = 1'b1;

  typedef enum logic [ErrW-1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_IDLE = 2'd2
  } err_e;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ClientW-1:0] client;
    logic [ResW-1:0]    resource;
    logic               granted;
    logic [ClientW-1:0] grant_client;
    logic [ResW-1:0]    grant_resource;
    err_e               err;
  } item_t;

endpackage

/* hw/rtl/fifo_resource_lock_manager.sv */
// top level: chain of resource cells, one cell per resource
// the item passes through the cells in order, each cell registers it before handing it on
// throughput: one item per cycle; each cell holds one queue and one waiter memory
// the whole chain holds while the result at the end is stalled
// reset clears valid bits, queue heads and counts; waiter memories are not cleared
module fifo_resource_lock_manager
  import frlm_pkg::*;
#(
  parameter int unsigned NUM_RESOURCES = 4,
  parameter int unsigned NUM_CLIENTS   = 8,
  parameter int unsigned QUEUE_DEPTH   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [ClientW-1:0] client_id_i,
  input  logic [ResW-1:0]    resource_id_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               granted_o,
  output logic [ClientW-1:0] grant_client_o,
  output logic [ResW-1:0]    grant_resource_o,
  output logic [ErrW-1:0]    error_o
);

  logic  en;
  logic  vld  [NUM_RESOURCES+1];
  item_t item [NUM_RESOURCES+1];

  assign en      = !(vld[NUM_RESOURCES] && stall_i);
  assign stall_o = !en;

  // entry item: unknown resource answers by kind
  always_comb begin
    item[0].kind           = kind_i;
    item[0].client         = client_id_i;
    item[0].resource       = resource_id_i;
    item[0].granted        = 1'b0;
    item[0].grant_client   = '0;
    item[0].grant_resource = '0;
    item[0].err            = (kind_i == KIND_REQUEST) ? ERR_FULL : ERR_IDLE;
  end
  assign vld[0] = valid_i;

  for (genvar k = 0; k < NUM_RESOURCES; k++) begin : g_cell
    frlm_cell #(
      .IDX        (k),
      .NUM_CLIENTS(NUM_CLIENTS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld[k]),
      .item_i(item[k]),
      .vld_o (vld[k+1]),
      .item_o(item[k+1])
    );
  end

  assign valid_o          = vld[NUM_RESOURCES];
  assign granted_o        = item[NUM_RESOURCES].granted;
  assign grant_client_o   = item[NUM_RESOURCES].grant_client;
  assign grant_resource_o = item[NUM_RESOURCES].grant_resource;
  assign error_o          = item[NUM_RESOURCES].err;

endmodule

/* hw/rtl/frlm_cell.sv */
// one resource cell: queue state and waiter memory, passes the item on
module frlm_cell
  import frlm_pkg::*;
#(
  parameter int unsigned IDX         = 0,
  parameter int unsigned NUM_CLIENTS = 8,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  item_t item_i,
  output logic  vld_o,
  output item_t item_o
);

  localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned NCW = 9;

  logic [ClientW-1:0] mem [QUEUE_DEPTH];
  logic [ClientW-1:0] rd_q;

  logic [PW-1:0] head_q, head_d, head_inc, tail;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] sum;
  logic          match, wr_en;
  logic          vld_q, pick_q, pick_d;
  item_t         item_q, item_d;

  assign match    = vld_i && (32'(item_i.resource) == IDX);
  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign sum      = SW'(head_q) + SW'(count_q);
  assign tail     = (sum >= SW'(QUEUE_DEPTH)) ? PW'(sum - SW'(QUEUE_DEPTH)) : PW'(sum);

  always_comb begin
    item_d  = item_i;
    head_d  = head_q;
    count_d = count_q;
    pick_d  = 1'b0;
    wr_en   = 1'b0;
    if (match) begin
      if (item_i.kind == KIND_REQUEST) begin
        if ((count_q < CW'(QUEUE_DEPTH)) &&
            (NCW'(item_i.client) < NCW'(NUM_CLIENTS))) begin
          wr_en      = 1'b1;
          count_d    = count_q + CW'(1);
          item_d.err = ERR_OK;
          if (count_q == '0) begin
            item_d.granted        = 1'b1;
            item_d.grant_client   = item_i.client;
            item_d.grant_resource = item_i.resource;
          end
        end else begin
          item_d.err = ERR_FULL;
        end
      end else begin
        if (count_q == '0) begin
          item_d.err = ERR_IDLE;
        end else begin
          head_d     = head_inc;
          count_d    = count_q - CW'(1);
          item_d.err = ERR_OK;
          if (count_q != CW'(1)) begin
            item_d.granted        = 1'b1;
            item_d.grant_resource = item_i.resource;
            pick_d                = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      pick_q  <= 1'b0;
      head_q  <= '0;
      count_q <= '0;
    end else if (en_i) begin
      vld_q   <= vld_i;
      pick_q  <= pick_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  // waiter memory, registered read of the next head
  always_ff @(posedge clk_i) begin
    if (en_i && wr_en) begin
      mem[tail] <= item_i.client;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mem[head_inc];
    end
  end

  always_comb begin
    item_o = item_q;
    if (pick_q) begin
      item_o.grant_client = rd_q;
    end
  end

  assign vld_o = vld_q;

endmodule

/* tb/frlm_checker.sv */
// checker for the fifo resource lock manager: watches both channels, predicts and compares
module frlm_checker
  import frlm_pkg::*;
#(
  parameter int unsigned NUM_RESOURCES = 4,
  parameter int unsigned NUM_CLIENTS   = 8,
  parameter int unsigned QUEUE_DEPTH   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [ClientW-1:0] client_id_i,
  input  logic [ResW-1:0]    resource_id_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               granted_i,
  input  logic [ClientW-1:0] grant_client_i,
  input  logic [ResW-1:0]    grant_resource_i,
  input  logic [ErrW-1:0]    error_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o
);

  typedef struct packed {
    logic               granted;
    logic [ClientW-1:0] client;
    logic [ResW-1:0]    resource;
    err_e               err;
  } grant_t;

  grant_t             grant_q[$];
  logic [ClientW-1:0] waiters   [NUM_RESOURCES][QUEUE_DEPTH];
  int unsigned        head_idx  [NUM_RESOURCES];
  int unsigned        depth_cnt [NUM_RESOURCES];
  int                 mismatches = 0;
  int                 pending    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  function automatic grant_t lock_step(logic [KindW-1:0] kind, logic [ClientW-1:0] client,
                                       logic [ResW-1:0] res);
    grant_t      g;
    int unsigned slot;
    g = '{granted: 1'b0, client: '0, resource: '0, err: ERR_OK};
    if (res >= NUM_RESOURCES) begin
      g.err = (kind == KIND_REQUEST) ? ERR_FULL : ERR_IDLE;
    end else if (kind == KIND_REQUEST) begin
      if (client >= NUM_CLIENTS || depth_cnt[res] >= QUEUE_DEPTH) begin
        g.err = ERR_FULL;
      end else begin
        slot = (head_idx[res] + depth_cnt[res]) % QUEUE_DEPTH;
        waiters[res][slot] = client;
        if (depth_cnt[res] == 0) begin
          g.granted  = 1'b1;
          g.client   = client;
          g.resource = res;
        end
        depth_cnt[res]++;
      end
    end else if (depth_cnt[res] == 0) begin
      g.err = ERR_IDLE;
    end else begin
      head_idx[res] = (head_idx[res] + 1) % QUEUE_DEPTH;
      depth_cnt[res]--;
      if (depth_cnt[res] != 0) begin
        g.granted  = 1'b1;
        g.client   = waiters[res][head_idx[res]];
        g.resource = res;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        head_idx[r]  = 0;
        depth_cnt[r] = 0;
      end
      grant_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: granted=%0d client=%0d resource=%0d error=%0d",
                     granted_i, grant_client_i, grant_resource_i, error_i);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          if (granted_i !== want.granted || grant_client_i !== want.client ||
              grant_resource_i !== want.resource || error_i !== want.err) begin
            if (mismatches < 10)
              $display("item mismatch: expected granted=%0d client=%0d resource=%0d error=%0d,",
                       want.granted, want.client, want.resource, want.err,
                       " got granted=%0d client=%0d resource=%0d error=%0d",
                       granted_i, grant_client_i, grant_resource_i, error_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        grant_q.push_back(lock_step(kind_i, client_id_i, resource_id_i));
      pending = grant_q.size();
    end
  end

endmodule

/* tb/tb_fifo_resource_lock_manager.sv */
// testbench top for the fifo resource lock manager: stimulus, receiver stalls and verdict
module tb_fifo_resource_lock_manager;
  import frlm_pkg::*;

  localparam int unsigned NumRes     = 4;
  localparam int unsigned NumClients = 8;
  localparam int unsigned QDepth     = 8;
  localparam int          RandItems  = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [KindW-1:0]   kind_i;
  logic [ClientW-1:0] client_id_i;
  logic [ResW-1:0]    resource_id_i;
  logic               valid_o;
  logic               stall_i;
  logic               granted_o;
  logic [ClientW-1:0] grant_client_o;
  logic [ResW-1:0]    grant_resource_o;
  logic [ErrW-1:0]    error_o;

  int mismatch_count;
  int pending_count;
  int src_idle_pct = 18;
  int snk_idle_pct = 18;
  bit hold_trigger = 1'b0;

  fifo_resource_lock_manager #(
    .NUM_RESOURCES(NumRes),
    .NUM_CLIENTS  (NumClients),
    .QUEUE_DEPTH  (QDepth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .kind_i          (kind_i),
    .client_id_i     (client_id_i),
    .resource_id_i   (resource_id_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .granted_o       (granted_o),
    .grant_client_o  (grant_client_o),
    .grant_resource_o(grant_resource_o),
    .error_o         (error_o)
  );

  frlm_checker #(
    .NUM_RESOURCES(NumRes),
    .NUM_CLIENTS  (NumClients),
    .QUEUE_DEPTH  (QDepth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (valid_i),
    .in_stall_i      (stall_o),
    .kind_i          (kind_i),
    .client_id_i     (client_id_i),
    .resource_id_i   (resource_id_i),
    .out_valid_i     (valid_o),
    .out_stall_i     (stall_i),
    .granted_i       (granted_o),
    .grant_client_i  (grant_client_o),
    .grant_resource_i(grant_resource_o),
    .error_i         (error_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 400000);
    $display("Mismatches found");
    $finish;
  end

  // receiver side, with one long hold-off so the block backs up
  initial begin
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        stall_i <= 1'b1;
        repeat (150) @(negedge clk_i);
        stall_i <= 1'b0;
      end else begin
        stall_i <= ($urandom_range(99) < snk_idle_pct);
      end
    end
  end

  task automatic send_item(logic [KindW-1:0] kind, logic [ClientW-1:0] client,
                           logic [ResW-1:0] res);
    while ($urandom_range(99) < src_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i       <= 1'b1;
    kind_i        <= kind;
    client_id_i   <= client;
    resource_id_i <= res;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    int rel_pct;
    logic [KindW-1:0] kind;
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    kind_i        = KIND_REQUEST;
    client_id_i   = '0;
    resource_id_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill one queue past full, then drain it past empty
    for (int c = 0; c < NumClients; c++) send_item(KIND_REQUEST, ClientW'(c), ResW'(0));
    send_item(KIND_REQUEST, 3'd7, 2'd0);
    send_item(KIND_RELEASE, 3'd7, 2'd3);
    send_item(KIND_REQUEST, 3'd5, 2'd3);
    send_item(KIND_REQUEST, 3'd2, 2'd1);
    send_item(KIND_REQUEST, 3'd6, 2'd2);
    for (int k = 0; k < QDepth; k++) begin
      send_item(KIND_RELEASE, (k % 2) ? 3'd7 : 3'd0, 2'd0);
    end
    send_item(KIND_RELEASE, 3'd0, 2'd0);
    send_item(KIND_RELEASE, 3'd3, 2'd3);
    send_item(KIND_RELEASE, 3'd0, 2'd1);
    send_item(KIND_RELEASE, 3'd7, 2'd2);

    for (int i = 0; i < RandItems; i++) begin
      if (i == 200) hold_trigger = 1'b1;
      if (i == 1000) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i == 1300) begin
        src_idle_pct = 18;
        snk_idle_pct = 18;
      end
      rel_pct = (i < 700) ? 35 : (i < 1400) ? 50 : 68;
      kind = ($urandom_range(99) < rel_pct) ? KIND_RELEASE : KIND_REQUEST;
      send_item(kind, ClientW'($urandom_range(NumClients - 1)),
                ResW'($urandom_range(NumRes - 1)));
    end
    valid_i <= 1'b0;

    wait (pending_count == 0);
    repeat (4 * NumRes + 20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
